>>> sv/assert_macros.svh
// Assertion macros used by the classifier unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/cppc_pkg.sv
// Package: register map, widths and location codes of the point classifier.
`timescale 1ns / 1ps
package cppc_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CORNER_W   = 48;
  localparam int PLANE_W    = 64;
  localparam int THR_W      = 16;
  localparam int THR_SQ_W   = 2 * THR_W;
  localparam int MUL_SPLIT  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CORNER_ONE,
    CFG_CORNER_TWO,
    CFG_CORNER_THREE,
    CFG_CORNER_FOUR,
    CFG_PLANE,
    CFG_CONE_THR,
    CFG_SURF_THR
  } cfg_index_t;

  typedef enum logic [1:0] {
    LOC_FRONT,
    LOC_ON,
    LOC_BEHIND
  } loc_t;

endpackage

>>> sv/cppc_if.sv
// Stream interfaces: scan points in, classification results out.
`timescale 1ns / 1ps
interface point_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface result_if;
  logic       valid;
  logic       ready;
  logic [1:0] location;
  logic       in_cone;
  logic       last_out;

  modport source (output valid, location, in_cone, last_out, input ready);
  modport sink   (input valid, location, in_cone, last_out, output ready);
endinterface

>>> sv/cppc_side.sv
// Pyramid side-plane test pipeline and the two-stage split multiplier it shares.
`timescale 1ns / 1ps

// partial products of MUL_SPLIT-bit slices in one stage, their sum in the next
module cppc_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic [AW+BW-1:0]   p
);

  localparam int S  = cppc_pkg::MUL_SPLIT;
  localparam int NA = (AW + S - 1) / S;
  localparam int NB = (BW + S - 1) / S;
  localparam int PW = AW + BW;

  logic [NA*S-1:0] a_ext;
  logic [NB*S-1:0] b_ext;
  logic [2*S-1:0]  pp [NA][NB];
  logic [PW-1:0]   sum_c;

  assign a_ext = (NA*S)'(a);
  assign b_ext = (NB*S)'(b);

  for (genvar i = 0; i < NA; i++) begin : g_a
    for (genvar j = 0; j < NB; j++) begin : g_b
      always_ff @(posedge clk) begin
        if (en) begin
          pp[i][j] <= a_ext[i*S +: S] * b_ext[j*S +: S];
        end
      end
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_c = sum_c + (PW'(pp[i][j]) << ((i + j) * S));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum_c;
    end
  end

endmodule

module cppc_side #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] corner [4][3],
  input  logic signed [COORD_BITS-1:0] pnt [3],
  input  logic [cppc_pkg::THR_W-1:0]   cone_thr,
  output logic                         in_pyr
);

  localparam int C    = COORD_BITS;
  localparam int NW   = 2 * C + 1;
  localparam int NNW  = 2 * NW + 2;
  localparam int DPW  = NW + C + 2;
  localparam int D2W  = 2 * DPW;
  localparam int TW   = cppc_pkg::THR_SQ_W + NNW;
  localparam int CW   = (D2W > TW) ? D2W : TW;
  localparam int NU [4] = '{2, 3, 2, 1};
  localparam int NV [4] = '{1, 0, 3, 0};
  localparam int NR [4] = '{3, 2, 1, 2};

  // stage 1
  logic signed [NW-1:0]          n1 [4][3];
  logic signed [C-1:0]           p1 [3];
  logic [cppc_pkg::THR_SQ_W-1:0] ct1;
  // stage 2
  logic signed [NNW-1:0]         nn2 [4];
  logic signed [DPW-1:0]         dp2 [4];
  logic signed [DPW-1:0]         rd2 [4];
  logic [cppc_pkg::THR_SQ_W-1:0] ct2;
  // stage 3
  logic                          dneg3 [4];
  logic                          dpos3 [4];
  logic                          nz3 [4];
  logic                          low_e1, left_e4;
  // stage 4, products land here
  logic                          dneg4 [4];
  logic                          dpos4 [4];
  logic                          nz4 [4];
  logic                          low_e1_d, left_e4_d;
  logic [3:0]                    fit, ok_lo, ok_hi;
  logic                          in_pyr_c;
  // stage 5
  logic                          in_pyr5;

  for (genvar k = 0; k < 4; k++) begin : g_plane
    logic signed [2*C-1:0]  pa [3];
    logic signed [2*C-1:0]  pb [3];
    logic signed [2*NW-1:0] sq [3];
    logic signed [NW+C-1:0] dt [3];
    logic signed [NW+C-1:0] rt [3];
    logic [DPW-1:0]         dmag;
    logic [D2W-1:0]         dsq4;
    logic [TW-1:0]          tn4;

    for (genvar i = 0; i < 3; i++) begin : g_comp
      assign pa[i] = corner[NU[k]][(i+1)%3] * corner[NV[k]][(i+2)%3];
      assign pb[i] = corner[NU[k]][(i+2)%3] * corner[NV[k]][(i+1)%3];
      assign sq[i] = n1[k][i] * n1[k][i];
      assign dt[i] = n1[k][i] * p1[i];
      assign rt[i] = n1[k][i] * corner[NR[k]][i];

      always_ff @(posedge clk) begin
        if (en) begin
          n1[k][i] <= NW'(pa[i]) - NW'(pb[i]);
        end
      end
    end

    assign dmag = $unsigned((dp2[k] < 0) ? -dp2[k] : dp2[k]);

    cppc_mul #(.AW(DPW), .BW(DPW)) u_dsq (
      .clk (clk),
      .en  (en),
      .a   (dmag),
      .b   (dmag),
      .p   (dsq4)
    );

    cppc_mul #(.AW(cppc_pkg::THR_SQ_W), .BW(NNW)) u_tn (
      .clk (clk),
      .en  (en),
      .a   (ct2),
      .b   ($unsigned(nn2[k])),
      .p   (tn4)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        nn2[k]   <= NNW'(sq[0]) + NNW'(sq[1]) + NNW'(sq[2]);
        dp2[k]   <= DPW'(dt[0]) + DPW'(dt[1]) + DPW'(dt[2]);
        rd2[k]   <= DPW'(rt[0]) + DPW'(rt[1]) + DPW'(rt[2]);
        dneg3[k] <= dp2[k] < 0;
        dpos3[k] <= dp2[k] > 0;
        nz3[k]   <= nn2[k] != '0;
        dneg4[k] <= dneg3[k];
        dpos4[k] <= dpos3[k];
        nz4[k]   <= nz3[k];
      end
    end

    assign fit[k]   = CW'(dsq4) <= CW'(tn4);
    assign ok_lo[k] = nz4[k] && (!dneg4[k] || fit[k]);
    assign ok_hi[k] = nz4[k] && (!dpos4[k] || fit[k]);
  end

  // plane roles follow the corner winding
  assign in_pyr_c = (low_e1_d  ? (ok_lo[0] && ok_hi[1]) : (ok_lo[1] && ok_hi[0])) &&
                    (left_e4_d ? (ok_lo[3] && ok_hi[2]) : (ok_lo[2] && ok_hi[3]));

  always_ff @(posedge clk) begin
    if (en) begin
      p1        <= pnt;
      ct1       <= cone_thr * cone_thr;
      ct2       <= ct1;
      low_e1    <= (rd2[0] > 0) && (rd2[1] < 0);
      left_e4   <= (rd2[2] < 0) && (rd2[3] > 0);
      low_e1_d  <= low_e1;
      left_e4_d <= left_e4;
      in_pyr5   <= in_pyr_c;
      in_pyr    <= in_pyr5;
    end
  end

endmodule

>>> sv/cppc_range.sv
// Ray/plane range pipeline: plane dot, point range, squared tolerance compare.
`timescale 1ns / 1ps
module cppc_range #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] coef [4],
  input  logic signed [COORD_BITS-1:0] pnt [3],
  input  logic [cppc_pkg::THR_W-1:0]   surf_thr,
  output cppc_pkg::loc_t               loc
);

  localparam int C   = COORD_BITS;
  localparam int SW  = 2 * C + 2;
  localparam int QW  = 2 * C + 2;
  localparam int DDW = SW + 1;
  localparam int QDW = QW + DDW;
  localparam int LW  = QDW + DDW;
  localparam int RW  = cppc_pkg::THR_SQ_W + 2 * SW;
  localparam int CW  = (LW > RW) ? LW : RW;

  logic signed [2*C-1:0]         pr [3];
  logic signed [2*C-1:0]         sq [3];
  logic signed [2*C-1:0]         pr1 [3];
  logic signed [2*C-1:0]         sq1 [3];
  logic signed [C-1:0]           d1;
  logic [cppc_pkg::THR_SQ_W-1:0] st1, st2, st3;
  logic signed [SW-1:0]          s_c, as_c;
  logic signed [C:0]             ad_c;
  logic signed [SW-1:0]          s2;
  logic signed [QW-1:0]          q2;
  logic signed [DDW-1:0]         dd2, dd3;
  logic [2*SW-1:0]               ss3;
  logic signed [QDW-1:0]         qd3;
  logic                          snz3, ddpos3, ddnz3;
  logic [QDW-1:0]                qmag;
  logic [DDW-1:0]                dmag;
  logic                          snz4, ddpos4, ddnz4;
  logic [LW-1:0]                 lhs5;
  logic [RW-1:0]                 rhs5;
  logic                          snz5, ddpos5, ddnz5;
  cppc_pkg::loc_t                loc_c;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign pr[i] = coef[i] * pnt[i];
    assign sq[i] = pnt[i] * pnt[i];
  end

  always_comb begin
    s_c  = SW'(pr1[0]) + SW'(pr1[1]) + SW'(pr1[2]);
    as_c = (s_c < 0) ? -s_c : s_c;
    ad_c = (C+1)'(d1);
    if (ad_c < 0) begin
      ad_c = -ad_c;
    end
  end

  // q is never negative, so q*dd*dd is |q*dd| * |dd|
  assign qmag = $unsigned((qd3 < 0) ? -qd3 : qd3);
  assign dmag = $unsigned((dd3 < 0) ? -dd3 : dd3);

  cppc_mul #(.AW(QDW), .BW(DDW)) u_lhs (
    .clk (clk),
    .en  (en),
    .a   (qmag),
    .b   (dmag),
    .p   (lhs5)
  );

  cppc_mul #(.AW(cppc_pkg::THR_SQ_W), .BW(2*SW)) u_rhs (
    .clk (clk),
    .en  (en),
    .a   (st3),
    .b   (ss3),
    .p   (rhs5)
  );

  always_comb begin
    if (!snz5) begin
      loc_c = cppc_pkg::LOC_FRONT;
    end else if (ddnz5 && (CW'(lhs5) > CW'(rhs5))) begin
      loc_c = ddpos5 ? cppc_pkg::LOC_BEHIND : cppc_pkg::LOC_FRONT;
    end else begin
      loc_c = cppc_pkg::LOC_ON;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr1    <= pr;
      sq1    <= sq;
      d1     <= coef[3];
      st1    <= surf_thr * surf_thr;
      s2     <= s_c;
      q2     <= QW'(sq1[0]) + QW'(sq1[1]) + QW'(sq1[2]);
      dd2    <= DDW'(as_c) - DDW'(ad_c);
      st2    <= st1;
      ss3    <= s2 * s2;
      qd3    <= q2 * dd2;
      dd3    <= dd2;
      snz3   <= s2 != '0;
      ddpos3 <= dd2 > 0;
      ddnz3  <= dd2 != '0;
      st3    <= st2;
      snz4   <= snz3;
      ddpos4 <= ddpos3;
      ddnz4  <= ddnz3;
      snz5   <= snz4;
      ddpos5 <= ddpos4;
      ddnz5  <= ddnz4;
      loc    <= loc_c;
    end
  end

endmodule

>>> sv/cone_plane_point_classifier_unit.sv
// Throughput: one point per cycle when not stalled; the six-stage multiply pipeline sets the latency.
// The whole pipeline stalls only while the final stage holds an untaken result.
// Reset (rst, synchronous) clears the pipeline valid bits and all config registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cone_plane_point_classifier_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  point_if.sink                                points,
  result_if.source                             results,
  input  logic                                 cfg_we,
  input  logic [cppc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cppc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int DEPTH = 6;

  logic [cppc_pkg::CORNER_W-1:0] corner_reg [4];
  logic [cppc_pkg::PLANE_W-1:0]  plane_reg;
  logic [cppc_pkg::THR_W-1:0]    cone_reg;
  logic [cppc_pkg::THR_W-1:0]    surf_reg;

  logic [3*C+cppc_pkg::CORNER_W-1:0] cext [4];
  logic [4*C+cppc_pkg::PLANE_W-1:0]  pext;
  logic signed [C-1:0]               corner_f [4][3];
  logic signed [C-1:0]               coef_f [4];
  logic signed [C-1:0]               pnt [3];

  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] lst;
  logic             en;
  logic             in_pyr;
  cppc_pkg::loc_t   loc;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_reg <= '{default: '0};
      plane_reg  <= '0;
      cone_reg   <= '0;
      surf_reg   <= '0;
    end else if (cfg_we) begin
      unique case (cppc_pkg::cfg_index_t'(cfg_index))
        cppc_pkg::CFG_CORNER_ONE:   corner_reg[0] <= cfg_data[cppc_pkg::CORNER_W-1:0];
        cppc_pkg::CFG_CORNER_TWO:   corner_reg[1] <= cfg_data[cppc_pkg::CORNER_W-1:0];
        cppc_pkg::CFG_CORNER_THREE: corner_reg[2] <= cfg_data[cppc_pkg::CORNER_W-1:0];
        cppc_pkg::CFG_CORNER_FOUR:  corner_reg[3] <= cfg_data[cppc_pkg::CORNER_W-1:0];
        cppc_pkg::CFG_PLANE:        plane_reg     <= cfg_data[cppc_pkg::PLANE_W-1:0];
        cppc_pkg::CFG_CONE_THR:     cone_reg      <= cfg_data[cppc_pkg::THR_W-1:0];
        cppc_pkg::CFG_SURF_THR:     surf_reg      <= cfg_data[cppc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // fields past the register top read as zero
  assign pext = {(4*C)'(0), plane_reg};
  for (genvar k = 0; k < 4; k++) begin : g_fields
    assign cext[k]   = {(3*C)'(0), corner_reg[k]};
    assign coef_f[k] = pext[k*C +: C];
    for (genvar i = 0; i < 3; i++) begin : g_xyz
      assign corner_f[k][i] = cext[k][i*C +: C];
    end
  end

  assign pnt[0] = points.point_x;
  assign pnt[1] = points.point_y;
  assign pnt[2] = points.point_z;

  assign en           = !vld[DEPTH-1] || results.ready;
  assign points.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], points.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst <= {lst[DEPTH-2:0], points.last_point};
    end
  end

  cppc_side #(.COORD_BITS(C)) u_side (
    .clk      (clk),
    .en       (en),
    .corner   (corner_f),
    .pnt      (pnt),
    .cone_thr (cone_reg),
    .in_pyr   (in_pyr)
  );

  cppc_range #(.COORD_BITS(C)) u_range (
    .clk      (clk),
    .en       (en),
    .coef     (coef_f),
    .pnt      (pnt),
    .surf_thr (surf_reg),
    .loc      (loc)
  );

  assign results.valid    = vld[DEPTH-1];
  assign results.location = in_pyr ? loc : cppc_pkg::LOC_FRONT;
  assign results.in_cone  = in_pyr;
  assign results.last_out = lst[DEPTH-1];

  `ASSERT_IMP(a_outside_front, clk, rst, results.valid && !results.in_cone, results.location == cppc_pkg::LOC_FRONT)
  `ASSERT_IMP(a_stall_blocks, clk, rst, results.valid && !results.ready, !points.ready)
  `ASSERT_NEXT(a_word_enters, clk, rst, points.valid && points.ready, vld[0])
  `ASSERT_IMP(a_loc_code, clk, rst, results.valid, results.location != 2'd3)

endmodule

>>> tb/testbench.sv
// Testbench for the cone/plane point classifier: random and directed scan points.
`timescale 1ns / 1ps
module testbench;

  localparam int CB = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    cppc_pkg::loc_t location;
    logic in_cone;
    logic last_out;
  } class_word_t;

  class point_class_tracker;
    logic [cppc_pkg::CORNER_W-1:0] corner [4];
    logic [cppc_pkg::PLANE_W-1:0]  plane;
    logic [cppc_pkg::THR_W-1:0]    cone_thr;
    logic [cppc_pkg::THR_W-1:0]    surf_thr;
    class_word_t                   expected_q [$];
    int                            errors;

    function new();
      foreach (corner[k]) corner[k] = '0;
      plane = '0;
      cone_thr = '0;
      surf_thr = '0;
      errors = 0;
    endfunction

    function void set_reg(cppc_pkg::cfg_index_t idx, logic [cppc_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        cppc_pkg::CFG_CORNER_ONE:   corner[0] = v[cppc_pkg::CORNER_W-1:0];
        cppc_pkg::CFG_CORNER_TWO:   corner[1] = v[cppc_pkg::CORNER_W-1:0];
        cppc_pkg::CFG_CORNER_THREE: corner[2] = v[cppc_pkg::CORNER_W-1:0];
        cppc_pkg::CFG_CORNER_FOUR:  corner[3] = v[cppc_pkg::CORNER_W-1:0];
        cppc_pkg::CFG_PLANE:        plane = v;
        cppc_pkg::CFG_CONE_THR:     cone_thr = v[cppc_pkg::THR_W-1:0];
        cppc_pkg::CFG_SURF_THR:     surf_thr = v[cppc_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    function wide_t dot3(longint u[3], longint v[3]);
      wide_t acc;
      acc = 0;
      for (int i = 0; i < 3; i++) acc += wide_t'(u[i]) * wide_t'(v[i]);
      return acc;
    endfunction

    // above: distance >= -T, otherwise distance <= T
    function bit side_pass(longint n[3], longint p[3], wide_t t2, bit above);
      wide_t nn;
      wide_t dp;
      nn = dot3(n, n);
      if (nn == 0) return 0;
      dp = dot3(n, p);
      if (!above) dp = -dp;
      if (dp >= 0) return 1;
      return (dp * dp) <= (t2 * nn);
    endfunction

    function void cross3(longint u[3], longint v[3], output longint n[3]);
      n[0] = u[1] * v[2] - u[2] * v[1];
      n[1] = u[2] * v[0] - u[0] * v[2];
      n[2] = u[0] * v[1] - u[1] * v[0];
    endfunction

    function void note_point(coord_t x, coord_t y, coord_t z, logic last);
      longint p [3];
      longint c [4][3];
      longint e [4][3];
      longint a, b, cc, d, s, as, ad, dd, q;
      wide_t ct2, st2, lhs, rhs;
      bit low_e1, left_e4, in_pyr;
      class_word_t w;
      p[0] = x; p[1] = y; p[2] = z;
      for (int k = 0; k < 4; k++)
        for (int i = 0; i < 3; i++) c[k][i] = longint'($signed(corner[k][i*CB +: CB]));
      cross3(c[2], c[1], e[0]);
      cross3(c[3], c[0], e[1]);
      cross3(c[2], c[3], e[2]);
      cross3(c[1], c[0], e[3]);
      low_e1 = dot3(e[0], c[3]) > 0 && dot3(e[1], c[2]) < 0;
      left_e4 = dot3(e[2], c[1]) < 0 && dot3(e[3], c[2]) > 0;
      ct2 = wide_t'({1'b0, cone_thr}) * wide_t'({1'b0, cone_thr});
      st2 = wide_t'({1'b0, surf_thr}) * wide_t'({1'b0, surf_thr});
      in_pyr = side_pass(e[low_e1 ? 0 : 1], p, ct2, 1)
            && side_pass(e[low_e1 ? 1 : 0], p, ct2, 0)
            && side_pass(e[left_e4 ? 3 : 2], p, ct2, 1)
            && side_pass(e[left_e4 ? 2 : 3], p, ct2, 0);
      w.location = cppc_pkg::LOC_FRONT;
      if (in_pyr) begin
        a  = longint'($signed(plane[0*CB +: CB]));
        b  = longint'($signed(plane[1*CB +: CB]));
        cc = longint'($signed(plane[2*CB +: CB]));
        d  = longint'($signed(plane[3*CB +: CB]));
        s = a * p[0] + b * p[1] + cc * p[2];
        if (s != 0) begin
          as = (s < 0) ? -s : s;
          ad = (d < 0) ? -d : d;
          dd = as - ad;
          q = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
          lhs = wide_t'(q) * wide_t'(dd) * wide_t'(dd);
          rhs = st2 * wide_t'(s) * wide_t'(s);
          if (dd != 0 && lhs > rhs)
            w.location = (dd > 0) ? cppc_pkg::LOC_BEHIND : cppc_pkg::LOC_FRONT;
          else w.location = cppc_pkg::LOC_ON;
        end
      end
      w.in_cone = in_pyr;
      w.last_out = last;
      expected_q.push_back(w);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [1:0] location, logic in_cone, logic last_out);
      class_word_t w;
      if (expected_q.size() == 0) begin
        report("result word with no point pending");
        return;
      end
      w = expected_q.pop_front();
      if (location !== w.location)
        report($sformatf("location got %0d want %0d", location, w.location));
      if (in_cone !== w.in_cone)
        report($sformatf("in_cone got %0b want %0b", in_cone, w.in_cone));
      if (last_out !== w.last_out)
        report($sformatf("last_out got %0b want %0b", last_out, w.last_out));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [cppc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cppc_pkg::CFG_DATA_W-1:0] cfg_data;

  point_if #(.COORD_BITS(CB)) pts ();
  result_if res ();

  cone_plane_point_classifier_unit #(.COORD_BITS(CB)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .points    (pts.sink),
    .results   (res.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  point_class_tracker tracker;
  bit hold_req;
  int idle_cycles;
  int burst_left;
  longint cn [4][3];   // corners of the current setting, for aiming points

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    tracker = new();
    rst <= 1;
    cfg_we <= 0;
    cfg_index <= '0;
    cfg_data <= '0;
    pts.valid <= 0;
    pts.point_x <= '0;
    pts.point_y <= '0;
    pts.point_z <= '0;
    pts.last_point <= 0;
    hold_req = 0;
    burst_left = 0;
    foreach (cn[k, i]) cn[k][i] = 0;
  end

  // Receiver: stall pattern is drawn at random from four modes; one long hold-off on request.
  initial begin
    int cyc;
    int mode;
    res.ready <= 0;
    cyc = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      if (hold_req) begin
        res.ready <= 0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 0;
      end else begin
        case (mode)
          0: res.ready <= 1;
          1: res.ready <= ($urandom_range(0, 3) != 0);
          2: res.ready <= (cyc % 8 < 5);
          default: res.ready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  // Handshakes are sampled mid-cycle, where every signal is settled.
  always @(negedge clk) begin
    if (!rst) begin
      if (pts.valid && pts.ready)
        tracker.note_point(pts.point_x, pts.point_y, pts.point_z, pts.last_point);
      if (res.valid && res.ready)
        tracker.check_result(res.location, res.in_cone, res.last_out);
      if ((pts.valid && pts.ready) || (res.valid && res.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  task write_reg(cppc_pkg::cfg_index_t idx, logic [cppc_pkg::CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    tracker.set_reg(idx, v);
  endtask

  function automatic logic [cppc_pkg::CORNER_W-1:0] pack_corner(longint x, longint y,
                                                                longint z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  // Writes every register; corners also kept for aiming points.
  task set_scene(longint c [4][3], longint a, longint b, longint c3, longint d,
                 int cone_t, int surf_t);
    for (int k = 0; k < 4; k++) begin
      write_reg(cppc_pkg::cfg_index_t'(cppc_pkg::CFG_CORNER_ONE + k),
                cppc_pkg::CFG_DATA_W'(pack_corner(c[k][0], c[k][1], c[k][2])));
      for (int i = 0; i < 3; i++) cn[k][i] = c[k][i];
    end
    write_reg(cppc_pkg::CFG_PLANE, {coord_t'(d), coord_t'(c3), coord_t'(b), coord_t'(a)});
    write_reg(cppc_pkg::CFG_CONE_THR, cppc_pkg::CFG_DATA_W'(cone_t));
    write_reg(cppc_pkg::CFG_SURF_THR, cppc_pkg::CFG_DATA_W'(surf_t));
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Wait for every result, then let the pipeline empty before touching config.
  task drain();
    pts.valid <= 0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Offer one point word; bursts keep valid high across words.
  task send_point(longint x, longint y, longint z, logic last);
    bit ok;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pts.valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    pts.valid <= 1;
    pts.point_x <= coord_t'(x);
    pts.point_y <= coord_t'(y);
    pts.point_z <= coord_t'(z);
    pts.last_point <= last;
    burst_left--;
    do begin
      @(negedge clk);
      ok = pts.ready;
      @(posedge clk);
    end while (!ok);
  endtask

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Mostly points aimed inside the pyramid near the plane range, rest full noise.
  task send_random_point();
    longint p [3];
    longint wt [4];
    longint wsum, k;
    logic last;
    last = ($urandom_range(0, 15) == 0);
    if ($urandom_range(0, 9) < 7) begin
      wsum = 0;
      foreach (wt[j]) begin
        wt[j] = $urandom_range(0, 255);
        wsum += wt[j];
      end
      if (wsum == 0) wsum = 1;
      k = $urandom_range(700, 1350);
      for (int i = 0; i < 3; i++) begin
        p[i] = 0;
        for (int j = 0; j < 4; j++) p[i] += wt[j] * cn[j][i];
        p[i] = p[i] / wsum * k / 1024 + $signed($urandom_range(0, 60)) - 30;
        p[i] = clamp16(p[i]);
      end
    end else begin
      for (int i = 0; i < 3; i++) p[i] = longint'(coord_t'($urandom()));
    end
    send_point(p[0], p[1], p[2], last);
  endtask

  task run_random(int count);
    repeat (count) send_random_point();
  endtask

  initial begin
    longint sq [4][3];
    longint rc [4][3];
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset setting: every side plane degenerate
    send_point(0, 0, 0, 0);
    send_point(32767, -32768, 100, 1);
    run_random(80);
    drain();

    sq = '{'{-500, -500, 1000}, '{500, -500, 1000}, '{500, 500, 1000}, '{-500, 500, 1000}};
    set_scene(sq, 0, 0, 1, -1000, 10, 20);
    // directed: origin, parallel ray, on/front/behind, outside, extremes, tolerance edges
    send_point(0, 0, 0, 0);
    send_point(100, 100, 0, 1);
    send_point(0, 0, 1000, 0);
    send_point(0, 0, 1010, 0);
    send_point(0, 0, 1030, 1);
    send_point(0, 0, 970, 0);
    send_point(250, -250, 500, 0);
    send_point(250, -250, 2000, 0);
    send_point(500, 500, 1000, 1);
    send_point(510, 0, 1000, 0);
    send_point(530, 0, 1000, 0);
    send_point(0, -520, 1000, 0);
    send_point(0, 0, -1000, 0);
    send_point(32767, 32767, 32767, 1);
    send_point(-32768, -32768, -32768, 0);
    send_point(-32768, 32767, 32767, 0);
    send_point(16000, -16000, 32767, 1);
    send_point(-1, -1, 32767, 0);
    send_point(0, 0, -32768, 0);
    drain();
    // sender keeps offering while the receiver holds off
    hold_req = 1;
    run_random(320);
    drain();

    // reversed corner order swaps the plane roles
    set_scene('{sq[3], sq[2], sq[1], sq[0]}, 0, 0, -1, 1000, 0, 0);
    run_random(280);
    drain();

    sq = '{'{-32768, -32768, 32767}, '{32767, -32768, 32767},
           '{32767, 32767, 32767}, '{-32768, 32767, 32767}};
    set_scene(sq, 0, 0, 32767, -32768, 65535, 65535);
    send_point(32767, 32767, 32767, 1);
    send_point(-32768, -32768, -32768, 0);
    run_random(280);
    drain();

    // random corners and plane
    for (int ph = 0; ph < 3; ph++) begin
      foreach (rc[k, i]) rc[k][i] = (i == 2) ? int'($urandom_range(200, 3000))
                                             : $signed($urandom_range(0, 4000)) - 2000;
      set_scene(rc, $signed($urandom_range(0, 200)) - 100, $signed($urandom_range(0, 200)) - 100,
                $urandom_range(1, 400), -$signed($urandom_range(0, 32767)),
                $urandom_range(0, 300), $urandom_range(0, 3000));
      run_random(250);
      drain();
    end

    // degenerate pyramid: two corners equal
    set_scene('{sq[0], sq[0], sq[2], sq[3]}, 1, 2, 3, 4, 100, 100);
    run_random(60);
    drain();

    repeat (10) @(posedge clk);
    if (tracker.errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule

>>> files.f
+incdir+sv
sv/cppc_pkg.sv
sv/cppc_if.sv
sv/cppc_side.sv
sv/cppc_range.sv
sv/cone_plane_point_classifier_unit.sv
tb/testbench.sv
